// File: sv/tqmh_pkg.sv
package tqmh_pkg;

  // Raw converter readings and calibration bounds
  localparam int RAW_W   = 12;
  localparam int DEB_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Map datapath: |raw - min| * (size - 1) fits in 24 bits, divisor is |max - min|
  localparam int SIZE_W  = 12;
  localparam int DVD_W   = 24;
  localparam int DVS_W   = 12;
  localparam int COORD_W = 12;
  localparam int BIDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN    = 3'd0,
    REG_X_MAX    = 3'd1,
    REG_Y_MIN    = 3'd2,
    REG_Y_MAX    = 3'd3,
    REG_DEBOUNCE = 3'd4,
    REG_PRESSURE = 3'd5
  } cfg_reg_t;

  localparam logic [RAW_W-1:0] X_MIN_RST    = 12'd300;
  localparam logic [RAW_W-1:0] X_MAX_RST    = 12'd3800;
  localparam logic [RAW_W-1:0] Y_MIN_RST    = 12'd300;
  localparam logic [RAW_W-1:0] Y_MAX_RST    = 12'd3800;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd200;
  localparam logic [RAW_W-1:0] PRESSURE_RST = 12'd200;

  // Button rectangles, half-open [x0, x1) by [y0, y1); lower index wins
  localparam int BTN_NUM = 5;
  localparam logic [COORD_W-1:0] BTN_X0 [BTN_NUM] = '{12'd5,   12'd123, 12'd5,  12'd65,  12'd130};
  localparam logic [COORD_W-1:0] BTN_X1 [BTN_NUM] = '{12'd117, 12'd235, 12'd60, 12'd120, 12'd235};
  localparam logic [COORD_W-1:0] BTN_Y0 [BTN_NUM] = '{12'd125, 12'd125, 12'd225, 12'd225, 12'd225};
  localparam logic [COORD_W-1:0] BTN_Y1 [BTN_NUM] = '{12'd175, 12'd175, 12'd265, 12'd265, 12'd265};

  typedef struct packed {
    logic              hit;
    logic [BIDX_W-1:0] idx;
  } hit_t;

endpackage

// File: sv/tqmh_div.sv
module tqmh_div
  import tqmh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  // one restoring step per cycle, MSB first
  logic [DVS_W:0] rem_sh;
  logic           take;
  logic [DVS_W:0] rem_sub;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign take    = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= take ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/tqmh_hit.sv
module tqmh_hit
  import tqmh_pkg::*;
(
  input  logic [COORD_W-1:0] px,
  input  logic [COORD_W-1:0] py,
  output hit_t               res
);

  // scan from the last button down so the first match wins
  always_comb begin
    res = '0;
    for (int i = BTN_NUM - 1; i >= 0; i--) begin
      if (px >= BTN_X0[i] && px < BTN_X1[i] && py >= BTN_Y0[i] && py < BTN_Y1[i]) begin
        res.hit = 1'b1;
        res.idx = BIDX_W'(i);
      end
    end
  end

endmodule

// File: sv/touch_qualify_map_hit_test_core.sv
// Touch sample qualifier, calibration map and button hit test.
//
// Input channel (in_valid/in_ready): one panel sample per transaction. A
// sample counts as a new touch on a press edge, when now_ms minus the last
// accepted time (mod 2^32) exceeds debounce_ms and pressure exceeds
// pressure_min. Accepted points are mapped onto the screen with truncating
// signed division, clamped, and tested against the button rectangles.
// Result channel (out_valid/out_ready): exactly one transaction per sample.
// Config channel (cfg_valid/cfg_ready): always ready; write only when idle.
//
// Sequence: a rejected sample goes straight to the final state, which loads
// the output register and then returns to idle. An accepted one runs each
// axis, x then y, through one shared multiply and a serial 24-step restoring
// divider; a zero-width window skips the divider and leaves the axis at 0.
// One sample is in flight at a time; in_ready is high only in idle.
// A finished result sits in the output register; the next sample may be
// taken meanwhile, and it waits at its final step while out_ready is low.
// Reset (synchronous, active low) restores the calibration defaults and
// clears the press history and the last accepted time.
module touch_qualify_map_hit_test_core
  import tqmh_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_pressed,
  input  logic [RAW_W-1:0]                 in_raw_x,
  input  logic [RAW_W-1:0]                 in_raw_y,
  input  logic [RAW_W-1:0]                 in_pressure,
  input  logic [TIME_W-1:0]                in_now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic                             out_hit,
  output logic [BIDX_W-1:0]                out_button_index,
  output logic [$clog2(SCREEN_WIDTH)-1:0]  out_screen_x,
  output logic [$clog2(SCREEN_HEIGHT)-1:0] out_screen_y,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // calibration registers
  logic [RAW_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r, pmin_r;
  logic [DEB_W-1:0] deb_r;

  // qualifier history
  logic              was_pressed_r;
  logic [TIME_W-1:0] last_ms_r;

  // sequencer and working registers
  state_t            state_r, state_nxt;
  logic              axis_r;      // 0: x, 1: y
  logic              acc_r;
  logic              neg_r;
  logic [RAW_W-1:0]  raw_x_r, raw_y_r;
  logic [XW-1:0]     sx_r;
  logic [YW-1:0]     sy_r;

  // output register
  logic              out_valid_r;
  logic              out_acc_r, out_hit_r;
  logic [BIDX_W-1:0] out_idx_r;
  logic [XW-1:0]     out_sx_r;
  logic [YW-1:0]     out_sy_r;

  logic in_fire, out_free, qualify;
  logic [TIME_W-1:0] elapsed;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign cfg_ready = 1'b1;

  assign elapsed = in_now_ms - last_ms_r;
  assign qualify = in_pressed & ~was_pressed_r & (elapsed > TIME_W'(deb_r)) &
                   (in_pressure > pmin_r);

  // ---- map operands for the current axis ----
  logic [RAW_W-1:0]  raw_sel, lo_sel, hi_sel;
  logic [SIZE_W-1:0] size_m1;
  logic [RAW_W:0]    num_d, run_d, num_abs, run_abs;
  logic              num_neg, run_neg, run_zero;
  logic [DVD_W-1:0]  prod;

  assign raw_sel = axis_r ? raw_y_r : raw_x_r;
  assign lo_sel  = axis_r ? y_min_r : x_min_r;
  assign hi_sel  = axis_r ? y_max_r : x_max_r;
  assign size_m1 = axis_r ? SIZE_W'(SCREEN_HEIGHT - 1) : SIZE_W'(SCREEN_WIDTH - 1);

  assign num_d    = {1'b0, raw_sel} - {1'b0, lo_sel};
  assign run_d    = {1'b0, hi_sel} - {1'b0, lo_sel};
  assign num_neg  = num_d[RAW_W];
  assign run_neg  = run_d[RAW_W];
  assign num_abs  = num_neg ? (~num_d + 1'b1) : num_d;
  assign run_abs  = run_neg ? (~run_d + 1'b1) : run_d;
  assign run_zero = (run_d == '0);
  assign prod     = DVD_W'(num_abs[RAW_W-1:0]) * DVD_W'(size_m1);

  // ---- shared serial divider ----
  logic             div_start, div_done;
  logic [DVD_W-1:0] quo;

  assign div_start = (state_r == S_MUL) & ~run_zero;

  tqmh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (run_abs[DVS_W-1:0]),
    .done     (div_done),
    .quotient (quo)
  );

  // clamp: negative quotient goes to 0, too large goes to the far edge
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;

  assign cx = neg_r ? '0 :
              (quo > DVD_W'(SCREEN_WIDTH - 1)) ? XW'(SCREEN_WIDTH - 1) : quo[XW-1:0];
  assign cy = neg_r ? '0 :
              (quo > DVD_W'(SCREEN_HEIGHT - 1)) ? YW'(SCREEN_HEIGHT - 1) : quo[YW-1:0];

  // ---- button hit test ----
  hit_t hres;

  tqmh_hit u_hit (
    .px  (COORD_W'(sx_r)),
    .py  (COORD_W'(sy_r)),
    .res (hres)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = qualify ? S_MUL : S_FIN;
      S_MUL:  if (!run_zero) state_nxt = S_DIV;
              else if (axis_r) state_nxt = S_FIN;
      S_DIV:  if (div_done) state_nxt = axis_r ? S_FIN : S_MUL;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      was_pressed_r <= 1'b0;
      last_ms_r     <= '0;
      x_min_r       <= X_MIN_RST;
      x_max_r       <= X_MAX_RST;
      y_min_r       <= Y_MIN_RST;
      y_max_r       <= Y_MAX_RST;
      deb_r         <= DEBOUNCE_RST;
      pmin_r        <= PRESSURE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_X_MIN:    x_min_r <= cfg_data[RAW_W-1:0];
          REG_X_MAX:    x_max_r <= cfg_data[RAW_W-1:0];
          REG_Y_MIN:    y_min_r <= cfg_data[RAW_W-1:0];
          REG_Y_MAX:    y_max_r <= cfg_data[RAW_W-1:0];
          REG_DEBOUNCE: deb_r   <= cfg_data;
          REG_PRESSURE: pmin_r  <= cfg_data[RAW_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        was_pressed_r <= in_pressed;
        if (qualify) last_ms_r <= in_now_ms;
      end
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r   <= qualify;
      raw_x_r <= in_raw_x;
      raw_y_r <= in_raw_y;
      axis_r  <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
    end
    if (state_r == S_MUL) begin
      neg_r <= num_neg ^ run_neg;
      if (run_zero) axis_r <= 1'b1;   // zero-width window leaves coordinate at 0
    end
    if (state_r == S_DIV && div_done) begin
      if (axis_r) sy_r <= cy;
      else        sx_r <= cx;
      axis_r <= 1'b1;
    end
    if (state_r == S_FIN && out_free) begin
      out_acc_r <= acc_r;
      out_hit_r <= acc_r & hres.hit;
      out_idx_r <= (acc_r & hres.hit) ? hres.idx : '0;
      out_sx_r  <= sx_r;
      out_sy_r  <= sy_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_hit          = out_hit_r;
  assign out_button_index = out_idx_r;
  assign out_screen_x     = out_sx_r;
  assign out_screen_y     = out_sy_r;

endmodule

// File: sv/tqmh_chk.sv
module tqmh_chk
  import tqmh_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_accepted,
  input logic                             out_hit,
  input logic [BIDX_W-1:0]                out_button_index,
  input logic [$clog2(SCREEN_WIDTH)-1:0]  out_screen_x,
  input logic [$clog2(SCREEN_HEIGHT)-1:0] out_screen_y
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) && $stable(out_hit) &&
    $stable(out_button_index) && $stable(out_screen_x) && $stable(out_screen_y))
    else $error("result changed under stall");

  // a rejected sample reports an all-zero point
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> !out_hit && out_button_index == '0 &&
    out_screen_x == '0 && out_screen_y == '0)
    else $error("rejected sample with nonzero fields");

  // hits only on accepted touches, valid button, else index 0
  a_hit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit ? (out_accepted && out_button_index <= BIDX_W'(BTN_NUM - 1))
                           : (out_button_index == '0)))
    else $error("bad hit / button index");

  // mapped point stays on the screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_screen_x) <= 32'(SCREEN_WIDTH - 1) &&
                  32'(out_screen_y) <= 32'(SCREEN_HEIGHT - 1))
    else $error("screen point out of range");

  // one sample at a time: no new sample taken in the cycle after one
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while busy");

endmodule

bind touch_qualify_map_hit_test_core tqmh_chk #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tqmh_chk (.*);

// File: tb/sv/testbench.sv
module testbench;
  import tqmh_pkg::*;

  localparam int SCR_W = 240;
  localparam int SCR_H = 320;
  localparam int SX_W = $clog2(SCR_W);
  localparam int SY_W = $clog2(SCR_H);

  // Watchdog limit for the whole run
  localparam int RUN_LIMIT = 800_000;
  // Longer than one mapped sample plus margin
  localparam int SETTLE_CYCLES = 80;
  // Long receiver hold-off, to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 400;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Button rectangles, [left, left+w) by [top, top+h); lowest index wins
  localparam int BTN_L [5] = '{5, 123, 5, 65, 130};
  localparam int BTN_T [5] = '{125, 125, 225, 225, 225};
  localparam int BTN_W [5] = '{112, 112, 55, 55, 105};
  localparam int BTN_H [5] = '{50, 50, 40, 40, 40};

  typedef struct packed {
    logic              pressed;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [RAW_W-1:0]  pressure;
    logic [TIME_W-1:0] now_ms;
  } panel_sample_t;

  typedef struct packed {
    logic              accepted;
    logic              hit;
    logic [BIDX_W-1:0] button;
    logic [SX_W-1:0]   sx;
    logic [SY_W-1:0]   sy;
  } touch_result_t;

  // Directed rows: sample fields, then whether the result is typed in, then the result
  typedef struct packed {
    int pressed;
    int raw_x;
    int raw_y;
    int pressure;
    int now_ms;
    int check;
    int accepted;
    int hit;
    int button;
    int sx;
    int sy;
  } directed_row_t;

  // All rows run under the reset calibration: window 300..3800, debounce 200, floor 200
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    //   pr     x     y     z  now_ms          chk acc hit btn  sx   sy
    '{0,    0,    0,    0,           0,    1, 0, 0, 0,   0,   0}, // idle panel after reset
    '{1, 4095, 4095, 4095,         100,    1, 0, 0, 0,   0,   0}, // too soon after time 0
    '{0,    0,    0,    0,        1001,    1, 0, 0, 0,   0,   0},
    '{1, 2000, 2000,  200,        2000,    1, 0, 0, 0,   0,   0}, // pressure equal to floor
    '{1, 2000, 2000, 4095,        3000,    1, 0, 0, 0,   0,   0}, // weak edge: no retry while held
    '{0, 2000, 2000,    0,        3001,    1, 0, 0, 0,   0,   0},
    '{1,    0,    0,  201,        5000,    1, 1, 0, 0,   0,   0}, // low corner clamps to 0
    '{0,    0,    0,    0,        5001,    1, 0, 0, 0,   0,   0},
    '{1, 4095, 4095, 4095,        5200,    1, 0, 0, 0,   0,   0}, // gap equal to debounce
    '{0,    0,    0,    0,        5201,    1, 0, 0, 0,   0,   0},
    '{1, 4095, 4095, 4095,        5201,    1, 1, 0, 0, 239, 319}, // high corner clamps
    '{0,    0,    0,    0,        5300,    1, 0, 0, 0,   0,   0},
    '{1, 1178, 1945, 3000,        6000,    0, 0, 0, 0,   0,   0}, // brew
    '{0,    0,    0,    0,        6001,    1, 0, 0, 0,   0,   0},
    '{1, 2936, 1945, 3000,        7000,    0, 0, 0, 0,   0,   0}, // stop
    '{0,    0,    0,    0,        7001,    1, 0, 0, 0,   0,   0},
    '{1,  739, 2988, 3000,        8000,    0, 0, 0, 0,   0,   0}, // minus
    '{0,    0,    0,    0,        8001,    1, 0, 0, 0,   0,   0},
    '{1, 1618, 2988, 3000,        9000,    0, 0, 0, 0,   0,   0}, // plus
    '{0,    0,    0,    0,        9001,    1, 0, 0, 0,   0,   0},
    '{1, 2936, 2988, 3000,       10000,    0, 0, 0, 0,   0,   0}, // calibrate
    '{0,    0,    0,    0, 32'hFFFF_FF00,  1, 0, 0, 0,   0,   0},
    '{1, 2048, 2048, 3000, 32'hFFFF_FFFF,  0, 0, 0, 0,   0,   0}, // top of the time range
    '{0,    0,    0,    0,           0,    1, 0, 0, 0,   0,   0},
    '{1, 2048, 2048, 3000, 32'h0000_00C9,  0, 0, 0, 0,   0,   0}  // gap spans the wrap
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_pressed;
  logic [RAW_W-1:0]     in_raw_x;
  logic [RAW_W-1:0]     in_raw_y;
  logic [RAW_W-1:0]     in_pressure;
  logic [TIME_W-1:0]    in_now_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_accepted;
  logic                 out_hit;
  logic [BIDX_W-1:0]    out_button_index;
  logic [SX_W-1:0]      out_screen_x;
  logic [SY_W-1:0]      out_screen_y;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  touch_qualify_map_hit_test_core #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pressed      (in_pressed),
    .in_raw_x        (in_raw_x),
    .in_raw_y        (in_raw_y),
    .in_pressure     (in_pressure),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_hit         (out_hit),
    .out_button_index(out_button_index),
    .out_screen_x    (out_screen_x),
    .out_screen_y    (out_screen_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 8-unit clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow of the block: calibration, debounce, pressure floor, press history
  logic [RAW_W-1:0]  cal_x_lo = 12'd300;
  logic [RAW_W-1:0]  cal_x_hi = 12'd3800;
  logic [RAW_W-1:0]  cal_y_lo = 12'd300;
  logic [RAW_W-1:0]  cal_y_hi = 12'd3800;
  logic [DEB_W-1:0]  min_gap_ms = 16'd200;
  logic [RAW_W-1:0]  press_floor = 12'd200;
  logic              prev_pressed = 1'b0;
  logic [TIME_W-1:0] last_touch_ms = '0;

  // Results owed by the block, oldest first
  touch_result_t touch_results_due [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;          // no idling on either side while set
  bit  hold_off_req = 1'b0;  // asks the receiver for one long stall

  // Stimulus walk state for well-formed press/release sequences
  logic [TIME_W-1:0] panel_ms = '0;
  logic              panel_down = 1'b0;

  // Linear map with truncating signed division, full-width product, then clamp
  function automatic longint scale_axis(input logic [RAW_W-1:0] raw, lo, hi, input int span);
    longint run;
    longint v;
    run = longint'(hi) - longint'(lo);
    if (run == 0) return 0;
    v = (longint'(raw) - longint'(lo)) * longint'(span - 1) / run;
    if (v < 0) v = 0;
    if (v > span - 1) v = span - 1;
    return v;
  endfunction

  // Predicts one result and advances the shadow press history
  function automatic touch_result_t qualify_touch(input panel_sample_t s);
    touch_result_t r;
    logic [TIME_W-1:0] elapsed;
    longint px;
    longint py;
    r = '0;
    elapsed = s.now_ms - last_touch_ms;  // wraps mod 2^32
    if (s.pressed && !prev_pressed && elapsed > min_gap_ms && s.pressure > press_floor) begin
      px = scale_axis(s.raw_x, cal_x_lo, cal_x_hi, SCR_W);
      py = scale_axis(s.raw_y, cal_y_lo, cal_y_hi, SCR_H);
      r.accepted = 1'b1;
      r.sx = px[SX_W-1:0];
      r.sy = py[SY_W-1:0];
      for (int b = 0; b < 5; b++) begin
        if (!r.hit && px >= BTN_L[b] && px < BTN_L[b] + BTN_W[b] &&
            py >= BTN_T[b] && py < BTN_T[b] + BTN_H[b]) begin
          r.hit = 1'b1;
          r.button = b[BIDX_W-1:0];
        end
      end
      last_touch_ms = s.now_ms;
    end
    // a rejected press edge still counts as pressed
    prev_pressed = s.pressed;
    return r;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_X_MIN:    cal_x_lo = data[RAW_W-1:0];
      REG_X_MAX:    cal_x_hi = data[RAW_W-1:0];
      REG_Y_MIN:    cal_y_lo = data[RAW_W-1:0];
      REG_Y_MAX:    cal_y_hi = data[RAW_W-1:0];
      REG_DEBOUNCE: min_gap_ms = data[DEB_W-1:0];
      REG_PRESSURE: press_floor = data[RAW_W-1:0];
      default: ;
    endcase
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Raw reading that lands near screen point pt under the current window
  function automatic logic [RAW_W-1:0] raw_for_point(input int pt,
                                                     input logic [RAW_W-1:0] lo, hi,
                                                     input int span);
    int v;
    v = int'(lo) + pt * (int'(hi) - int'(lo)) / (span - 1);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[RAW_W-1:0];
  endfunction

  // Mostly press/release sequences with time moving past the debounce window,
  // pressure over the floor and, about half the time, points aimed at buttons; the rest is noise.
  function automatic panel_sample_t random_sample();
    panel_sample_t s;
    int b;
    s.pressed = 1'($urandom_range(0, 1));
    s.raw_x = RAW_W'($urandom_range(0, 4095));
    s.raw_y = RAW_W'($urandom_range(0, 4095));
    s.pressure = RAW_W'($urandom_range(0, 4095));
    s.now_ms = $urandom();
    if ($urandom_range(0, 99) < 15) begin
      panel_ms = s.now_ms;
      panel_down = s.pressed;
      return s;
    end
    if ($urandom_range(0, 9) < 7) panel_down = !panel_down;
    if ($urandom_range(0, 9) < 8) panel_ms += min_gap_ms + 1 + $urandom_range(0, 300);
    else panel_ms += $urandom_range(0, min_gap_ms);
    s.pressed = panel_down;
    s.now_ms = panel_ms;
    if (press_floor != '1 && $urandom_range(0, 9) < 8)
      s.pressure = RAW_W'($urandom_range(press_floor + 1, 4095));
    if ($urandom_range(0, 1) != 0) begin
      b = $urandom_range(0, 4);
      s.raw_x = raw_for_point(BTN_L[b] + $urandom_range(0, BTN_W[b] - 1),
                              cal_x_lo, cal_x_hi, SCR_W);
      s.raw_y = raw_for_point(BTN_T[b] + $urandom_range(0, BTN_H[b] - 1),
                              cal_y_lo, cal_y_hi, SCR_H);
    end
    return s;
  endfunction

  // One input transaction; valid stays up with a stable payload until taken
  task automatic offer(input panel_sample_t s, input bit typed, input touch_result_t typed_res);
    int gap;
    touch_result_t predicted;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_pressed  <= s.pressed;
    in_raw_x    <= s.raw_x;
    in_raw_y    <= s.raw_y;
    in_pressure <= s.pressure;
    in_now_ms   <= s.now_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = qualify_touch(s);
    touch_results_due.push_back(typed ? typed_res : predicted);
  endtask

  // Stop offering, wait for every owed result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (touch_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_calibration(input logic [CFG_DATA_W-1:0] x_lo, x_hi, y_lo, y_hi,
                                 input logic [CFG_DATA_W-1:0] gap, floor_z);
    write_reg(REG_X_MIN, x_lo);
    write_reg(REG_X_MAX, x_hi);
    write_reg(REG_Y_MIN, y_lo);
    write_reg(REG_Y_MAX, y_hi);
    write_reg(REG_DEBOUNCE, gap);
    write_reg(REG_PRESSURE, floor_z);
  endtask

  // Result side: out_ready changes on the falling edge. Random stalls, plus
  // one long hold-off on request so the block backs up and drops in_ready.
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        stall = idle_len();
        out_ready <= (stall == 0);
      end
    end
  end

  // Every result transaction is matched against the oldest owed result
  always @(posedge clk) begin : check_results
    touch_result_t got;
    touch_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_accepted, out_hit, out_button_index, out_screen_x, out_screen_y};
      if (touch_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none owed: acc=%0d hit=%0d btn=%0d x=%0d y=%0d",
                   $realtime, got.accepted, got.hit, got.button, got.sx, got.sy);
      end else begin
        want = touch_results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected acc=%0d hit=%0d btn=%0d x=%0d y=%0d, got acc=%0d hit=%0d btn=%0d x=%0d y=%0d",
                     $realtime, want.accepted, want.hit, want.button, want.sx, want.sy,
                     got.accepted, got.hit, got.button, got.sx, got.sy);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    panel_sample_t s;
    touch_result_t e;
    int n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pressed  = 1'b0;
    in_raw_x    = '0;
    in_raw_y    = '0;
    in_pressure = '0;
    in_now_ms   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_X_MIN;
    cfg_data    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk under the reset calibration
    foreach (DIRECTED_ROWS[i]) begin
      s.pressed  = DIRECTED_ROWS[i].pressed[0];
      s.raw_x    = DIRECTED_ROWS[i].raw_x[RAW_W-1:0];
      s.raw_y    = DIRECTED_ROWS[i].raw_y[RAW_W-1:0];
      s.pressure = DIRECTED_ROWS[i].pressure[RAW_W-1:0];
      s.now_ms   = DIRECTED_ROWS[i].now_ms;
      e.accepted = DIRECTED_ROWS[i].accepted[0];
      e.hit      = DIRECTED_ROWS[i].hit[0];
      e.button   = DIRECTED_ROWS[i].button[BIDX_W-1:0];
      e.sx       = DIRECTED_ROWS[i].sx[SX_W-1:0];
      e.sy       = DIRECTED_ROWS[i].sy[SY_W-1:0];
      offer(s, DIRECTED_ROWS[i].check != 0, e);
    end
    settle();

    // Random phases, each under its own calibration, written while idle
    for (int phase = 0; phase < 7; phase++) begin
      calm = 1'b0;
      case (phase)
        0: begin
          // reset values again, with junk above the 12-bit width of x_min, x_max, y_min and the pressure floor
          set_calibration(16'hF12C, 16'hAED8, 16'h512C, 16'h0ED8, 16'd200, 16'h70C8);
          write_reg(REG_SPARE_6, 16'hFFFF);
          write_reg(REG_SPARE_7, 16'h5A5A);
          calm = 1'b1;
          n = 100;
        end
        1: begin
          // widest window, no debounce, no pressure floor
          set_calibration(16'd0, 16'd4095, 16'd0, 16'd4095, 16'd0, 16'd0);
          n = 120;
        end
        2: begin
          // inverted window on both axes: negative slope, then clamping
          set_calibration(16'd4095, 16'd0, 16'd3800, 16'd300, 16'd50, 16'd1000);
          n = 120;
        end
        3: begin
          // zero-width window on both axes, longest debounce
          set_calibration(16'd2000, 16'd2000, 16'd0, 16'd0, 16'hFFFF, 16'd100);
          n = 80;
        end
        4: begin
          // floor at its top: nothing can be accepted; one-count windows
          set_calibration(16'd0, 16'd1, 16'd4095, 16'd4094, 16'hFFFF, 16'd4095);
          n = 40;
        end
        default: begin
          set_calibration(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                          CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                          CFG_DATA_W'($urandom_range(0, 1000)),
                          CFG_DATA_W'($urandom_range(0, 3000)));
          n = 130;
        end
      endcase
      for (int k = 0; k < n; k++) begin
        if (phase == 2 && k == 40) hold_off_req = 1'b1;
        if (phase >= 5 && k == n / 2) settle();
        offer(random_sample(), 1'b0, '0);
      end
      settle();
    end

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/tqmh_pkg.sv
sv/tqmh_div.sv
sv/tqmh_hit.sv
sv/touch_qualify_map_hit_test_core.sv
sv/tqmh_chk.sv
tb/sv/testbench.sv
